>>> hdl/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg: shared constants for the small matrix inverse core
// Default widths and the index pairs that form each cofactor of a 3x3 matrix.
// ----------------------------------------------------------------------------
package smi_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int N_ELEM         = 9;

  // Adjugate entry j = a[COF_IDX[j][0]]*a[COF_IDX[j][1]] - a[COF_IDX[j][2]]*a[COF_IDX[j][3]],
  // with elements in row-major positions.
  localparam int COF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

endpackage

>>> hdl/small_matrix_inverse_core.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse_core: 2x2 / 3x3 fixed-point matrix inverse
// Determinant and adjugate with exact intermediate products, then one
// rounded, saturated long division per element in a bit-per-stage pipeline.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Width                 Contents
// s_*      in   9*DATA_WIDTH (bytes)  tdata: elem_r0c0 .. elem_r2c2 (lowest first)
//                                     tuser: order_is_three
// m_*      out  9*DATA_WIDTH (bytes)  tdata: inv_r0c0 .. inv_r2c2 (lowest first)
//                                     tuser: singular
//
// One matrix can be accepted every clock cycle while the output is not stalled
// on m_tready. The pipeline holds eight stages for the input register, products,
// cofactors, determinant and magnitudes, one divider preparation stage, one stage
// per quotient bit (DATA_WIDTH+2 bits of the restoring divider), then rounding
// and sign restoration. The divider depth sets the latency.
// Reset (rst, synchronous) clears only the stage valid bits.
// Each stage holds its transfer until the next stage can take it, so a stall
// on m_tready fills empty stages first and never drops or repeats a matrix.
//
module small_matrix_inverse_core #(
  parameter int DATA_WIDTH = smi_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = smi_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, ... elem_r2c2, zero fill
  input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // order_is_three
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, ... inv_r2c2, zero fill
  output logic [((9*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // singular
  output logic m_tuser
);

  localparam int NE  = smi_pkg::N_ELEM;
  localparam int DW  = DATA_WIDTH;
  localparam int PW  = 2*DW;          // element product
  localparam int KW  = 2*DW+1;        // cofactor
  localparam int DTW = 3*DW+3;        // determinant
  localparam int QB  = DW+2;          // quotient bits of 2*N/M
  localparam int XW  = KW+2*FRAC_BITS+1;
  localparam int CW  = (XW > DTW+QB) ? XW : DTW+QB;
  localparam int RW  = DTW;           // divider remainder
  localparam int ST_PREP = 8;
  localparam int NS  = ST_PREP+QB+3;

  // Stage valid bits and the per-stage ready chain.
  logic [NS-1:0] vld;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld[NS-1] || m_tready;
    for (int i = NS-2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: input register.
  logic signed [DW-1:0] st0_a [NE];
  logic                 st0_three;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      for (int j = 0; j < NE; j++) begin
        st0_a[j] <= s_tdata[j*DW +: DW];
      end
      st0_three <= s_tuser;
    end
  end

  // Stage 1: the eighteen element products behind the cofactors.
  logic signed [PW-1:0] st1_p0 [NE];
  logic signed [PW-1:0] st1_p1 [NE];
  logic signed [DW-1:0] st1_a  [NE];
  logic                 st1_three;

  for (genvar j = 0; j < NE; j++) begin : g_prod
    always_ff @(posedge clk) begin
      if (rdy[1]) begin
        st1_p0[j] <= st0_a[smi_pkg::COF_IDX[j][0]] * st0_a[smi_pkg::COF_IDX[j][1]];
        st1_p1[j] <= st0_a[smi_pkg::COF_IDX[j][2]] * st0_a[smi_pkg::COF_IDX[j][3]];
        st1_a[j]  <= st0_a[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      st1_three <= st0_three;
    end
  end

  // Stage 2: cofactors. The adjugate for order two is taken straight from the
  // elements; its determinant equals the last 3x3 cofactor.
  logic signed [KW-1:0] kc [NE];
  logic signed [KW-1:0] k_two [NE];
  logic signed [KW-1:0] st2_k  [NE];
  logic signed [KW-1:0] st2_kd [3];
  logic signed [DW-1:0] st2_a  [3];
  logic signed [KW-1:0] st2_d2;
  logic                 st2_three;

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      kc[j]    = KW'(st1_p0[j]) - KW'(st1_p1[j]);
      k_two[j] = '0;
    end
    k_two[0] = KW'(st1_a[4]);
    k_two[1] = -KW'(st1_a[1]);
    k_two[3] = -KW'(st1_a[3]);
    k_two[4] = KW'(st1_a[0]);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      if (st1_three) begin
        st2_k <= kc;
      end else begin
        st2_k <= k_two;
      end
      st2_kd[0] <= kc[0];
      st2_kd[1] <= kc[3];
      st2_kd[2] <= kc[6];
      for (int j = 0; j < 3; j++) begin
        st2_a[j] <= st1_a[j];
      end
      st2_d2    <= kc[8];
      st2_three <= st1_three;
    end
  end

  // Stage 3: first-row element times cofactor, split into a low unsigned
  // half and a high signed half of the cofactor.
  logic signed [KW-1:0] st3_lo [3];
  logic signed [KW-1:0] st3_hi [3];
  logic signed [KW-1:0] st3_k  [NE];
  logic signed [KW-1:0] st3_d2;
  logic                 st3_three;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int j = 0; j < 3; j++) begin
        st3_lo[j] <= st2_a[j] * $signed({1'b0, st2_kd[j][DW-1:0]});
        st3_hi[j] <= st2_a[j] * $signed(st2_kd[j][KW-1:DW]);
      end
      st3_k     <= st2_k;
      st3_d2    <= st2_d2;
      st3_three <= st2_three;
    end
  end

  // Stage 4: recombine the partial products.
  logic signed [DTW-1:0] st4_t [3];
  logic signed [KW-1:0]  st4_k [NE];
  logic signed [KW-1:0]  st4_d2;
  logic                  st4_three;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int j = 0; j < 3; j++) begin
        st4_t[j] <= (DTW'(st3_hi[j]) <<< DW) + DTW'(st3_lo[j]);
      end
      st4_k     <= st3_k;
      st4_d2    <= st3_d2;
      st4_three <= st3_three;
    end
  end

  // Stage 5: first partial sum of the determinant.
  logic signed [DTW-1:0] st5_s;
  logic signed [DTW-1:0] st5_t2;
  logic signed [KW-1:0]  st5_k [NE];
  logic signed [KW-1:0]  st5_d2;
  logic                  st5_three;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      st5_s     <= st4_t[0] + st4_t[1];
      st5_t2    <= st4_t[2];
      st5_k     <= st4_k;
      st5_d2    <= st4_d2;
      st5_three <= st4_three;
    end
  end

  // Stage 6: determinant for the selected order.
  logic signed [DTW-1:0] st6_d;
  logic signed [KW-1:0]  st6_k [NE];

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      st6_d <= st5_three ? (st5_s + st5_t2) : DTW'(st5_d2);
      st6_k <= st5_k;
    end
  end

  // Stage 7: magnitudes, quotient signs and the singular test.
  logic [DTW-1:0] st7_m;
  logic [KW-1:0]  st7_n   [NE];
  logic [NE-1:0]  st7_neg;
  logic           st7_sing;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      st7_m    <= st6_d[DTW-1] ? DTW'(-st6_d) : DTW'(st6_d);
      st7_sing <= (st6_d == '0);
      for (int j = 0; j < NE; j++) begin
        st7_n[j]   <= st6_k[j][KW-1] ? KW'(-st6_k[j]) : KW'(st6_k[j]);
        st7_neg[j] <= st6_k[j][KW-1] ^ st6_d[DTW-1];
      end
    end
  end

  // Stage 8 and the divider steps. Index 0 is the preparation stage: the
  // dividend 2*|K|*2^(2F) is checked against M*2^QB for overflow, and its
  // high part seeds the remainder. Each later index retires one quotient bit.
  logic [RW-1:0]  dv_r   [QB+1][NE];
  logic [QB-1:0]  dv_x   [QB+1][NE];
  logic [QB-1:0]  dv_q   [QB+1][NE];
  logic [NE-1:0]  dv_ovf [QB+1];
  logic [NE-1:0]  dv_neg [QB+1];
  logic [RW-1:0]  dv_m   [QB+1];
  logic           dv_sing[QB+1];

  logic [CW-1:0]  pr_x [NE];
  logic [CW-1:0]  pr_mx;

  always_comb begin
    pr_mx = CW'(st7_m) << QB;
    for (int j = 0; j < NE; j++) begin
      pr_x[j] = CW'(st7_n[j]) << (2*FRAC_BITS+1);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_PREP]) begin
      for (int j = 0; j < NE; j++) begin
        dv_r[0][j]   <= RW'(pr_x[j] >> QB);
        dv_x[0][j]   <= pr_x[j][QB-1:0];
        dv_q[0][j]   <= '0;
        dv_ovf[0][j] <= (pr_x[j] >= pr_mx);
      end
      dv_neg[0]  <= st7_neg;
      dv_m[0]    <= RW'(st7_m);
      dv_sing[0] <= st7_sing;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_div
    logic [RW:0] trial [NE];
    logic [NE-1:0] take;

    always_comb begin
      for (int j = 0; j < NE; j++) begin
        trial[j] = {dv_r[s-1][j], dv_x[s-1][j][QB-1]};
        take[j]  = (trial[j] >= (RW+1)'(dv_m[s-1]));
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[ST_PREP+s]) begin
        for (int j = 0; j < NE; j++) begin
          dv_r[s][j] <= take[j] ? RW'(trial[j] - (RW+1)'(dv_m[s-1])) : RW'(trial[j]);
          dv_x[s][j] <= dv_x[s-1][j] << 1;
          dv_q[s][j] <= {dv_q[s-1][j][QB-2:0], take[j]};
        end
        dv_ovf[s]  <= dv_ovf[s-1];
        dv_neg[s]  <= dv_neg[s-1];
        dv_m[s]    <= dv_m[s-1];
        dv_sing[s] <= dv_sing[s-1];
      end
    end
  end

  // Rounding stage: floor(2N/M) halved with its low bit added gives N/M
  // rounded half away from zero; then saturate against the signed range.
  localparam logic [QB-1:0] LIM_POS = QB'((64'd1 << (DW-1)) - 64'd1);
  localparam logic [QB-1:0] LIM_NEG = QB'(64'd1 << (DW-1));

  logic [QB-1:0] rd_q   [NE];
  logic [QB-1:0] rd_lim [NE];
  logic [DW-1:0] st_rd_mag [NE];
  logic [NE-1:0] st_rd_neg;
  logic          st_rd_sing;

  always_comb begin
    for (int j = 0; j < NE; j++) begin
      rd_q[j]   = (dv_q[QB][j] >> 1) + QB'(dv_q[QB][j][0]);
      rd_lim[j] = dv_neg[QB][j] ? LIM_NEG : LIM_POS;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-2]) begin
      for (int j = 0; j < NE; j++) begin
        if (dv_ovf[QB][j] || (rd_q[j] > rd_lim[j])) begin
          st_rd_mag[j] <= rd_lim[j][DW-1:0];
        end else begin
          st_rd_mag[j] <= rd_q[j][DW-1:0];
        end
      end
      st_rd_neg  <= dv_neg[QB];
      st_rd_sing <= dv_sing[QB];
    end
  end

  // Output stage: restore the sign; a singular matrix gives all zeros.
  logic [DW-1:0] out_inv [NE];
  logic          out_sing;

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      for (int j = 0; j < NE; j++) begin
        if (st_rd_sing) begin
          out_inv[j] <= '0;
        end else begin
          out_inv[j] <= st_rd_neg[j] ? DW'(-st_rd_mag[j]) : st_rd_mag[j];
        end
      end
      out_sing <= st_rd_sing;
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int j = 0; j < NE; j++) begin
      m_tdata[j*DW +: DW] = out_inv[j];
    end
  end

  assign m_tuser = out_sing;

endmodule
